// File: hdl/zero_crossing_tone_estimator_core_macros.svh
// Assertion macros shared by the estimator RTL.
`ifndef ZERO_CROSSING_TONE_ESTIMATOR_CORE_MACROS_SVH
`define ZERO_CROSSING_TONE_ESTIMATOR_CORE_MACROS_SVH

`ifndef ASSERT_OFF
`define ZCTE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ZCTE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ZCTE_ASSERT(lbl, clk, rst_n, prop, msg)
`define ZCTE_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// File: hdl/zcte_pkg.sv
package zcte_pkg;

  localparam int TIMER_BITS_DEF = 16;
  localparam int SUM_BITS_DEF   = 24;

  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = 6;
  localparam int TONE_BITS   = 26;
  localparam int ITER_BITS   = $clog2(TONE_BITS + 1);
  localparam int CFG_ADDR_BITS = 3;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX  = '1;
  localparam logic [TONE_BITS-1:0]  TONE_SCALE = TONE_BITS'(600000);
  localparam logic [ITER_BITS-1:0]  ITER_LOAD  = ITER_BITS'(TONE_BITS);

  localparam logic                  DETECT_ENABLE_RST   = 1'b1;
  localparam logic [COUNT_BITS-1:0] CROSSING_TARGET_RST = COUNT_BITS'(30);

  typedef enum logic {
    REG_DETECT_ENABLE   = 1'b0,
    REG_CROSSING_TARGET = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic                  detect_enable;
    logic [COUNT_BITS-1:0] crossing_target;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_HOLD
  } state_t;

endpackage

// File: hdl/zcte_regs.sv
module zcte_regs
  import zcte_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [CFG_DATA_BITS-1:0] pwdata,
  output logic [CFG_DATA_BITS-1:0] prdata,
  output logic                     pready,
  output cfg_t                     cfg_o
);

  cfg_t       cfg_r;
  reg_index_t idx;
  logic       wr_en;

  assign idx    = reg_index_t'(paddr[2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.detect_enable   <= DETECT_ENABLE_RST;
      cfg_r.crossing_target <= CROSSING_TARGET_RST;
    end else if (wr_en) begin
      case (idx)
        REG_DETECT_ENABLE:   cfg_r.detect_enable   <= pwdata[0];
        REG_CROSSING_TARGET: cfg_r.crossing_target <= pwdata[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_DETECT_ENABLE:   prdata = CFG_DATA_BITS'(cfg_r.detect_enable);
      REG_CROSSING_TARGET: prdata = CFG_DATA_BITS'(cfg_r.crossing_target);
      default:             prdata = '0;
    endcase
  end

endmodule

// File: hdl/zcte_track.sv
module zcte_track
  import zcte_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF,
  parameter int SUM_BITS   = SUM_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step_i,
  input  logic                   clear_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output logic [COUNT_BITS-1:0]  count_upd_o,
  output logic [SUM_BITS-1:0]    sum_upd_o
);

  localparam int ADD_BITS = ((SUM_BITS > TIMER_BITS) ? SUM_BITS : TIMER_BITS) + 1;

  logic [SAMPLE_BITS-1:0] prev_r;
  logic [TIMER_BITS-1:0]  timer_r, timer_nxt;
  logic [SUM_BITS-1:0]    sum_r;
  logic [COUNT_BITS-1:0]  count_r;

  logic                   prev_neg, prev_pos, cur_neg, cur_pos, crossing;
  logic [ADD_BITS-1:0]    add_w;

  assign prev_neg = prev_r[SAMPLE_BITS-1];
  assign prev_pos = !prev_r[SAMPLE_BITS-1] && (prev_r != '0);
  assign cur_neg  = sample_i[SAMPLE_BITS-1];
  assign cur_pos  = !sample_i[SAMPLE_BITS-1] && (sample_i != '0);
  assign crossing = (prev_neg && cur_pos) || (prev_pos && cur_neg);
  assign add_w    = ADD_BITS'(sum_r) + ADD_BITS'(timer_r);

  always_comb begin
    count_upd_o = count_r;
    sum_upd_o   = sum_r;
    timer_nxt   = timer_r;
    if (crossing) begin
      timer_nxt = '0;
      sum_upd_o = (add_w[ADD_BITS-1:SUM_BITS] != '0) ? '1 : add_w[SUM_BITS-1:0];
      if (count_r != COUNT_MAX) begin
        count_upd_o = count_r + COUNT_BITS'(1);
      end
    end else if (timer_r != '1) begin
      timer_nxt = timer_r + TIMER_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r  <= '0;
      timer_r <= '0;
      sum_r   <= '0;
      count_r <= '0;
    end else if (step_i) begin
      prev_r  <= sample_i;
      timer_r <= timer_nxt;
      sum_r   <= clear_i ? '0 : sum_upd_o;
      count_r <= clear_i ? '0 : count_upd_o;
    end
  end

endmodule

// File: hdl/zcte_div.sv
`include "zero_crossing_tone_estimator_core_macros.svh"

module zcte_div
  import zcte_pkg::*;
#(
  parameter int SUM_BITS = SUM_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start_i,
  input  logic [COUNT_BITS-1:0] count_i,
  input  logic [SUM_BITS-1:0]   divisor_i,
  output logic                  busy_o,
  output logic                  done_o,
  output logic [TONE_BITS-1:0]  quotient_o
);

  logic                 busy_r, busy_nxt;
  logic [ITER_BITS-1:0] cnt_r, cnt_nxt;
  logic [SUM_BITS:0]    rem_r, rem_nxt;
  logic [TONE_BITS-1:0] quo_r, quo_nxt;
  logic [SUM_BITS-1:0]  div_r;

  logic [SUM_BITS:0]    rem_sh;
  logic                 ge;
  logic [TONE_BITS-1:0] prod;

  assign prod   = TONE_SCALE * TONE_BITS'(count_i);
  assign rem_sh = {rem_r[SUM_BITS-1:0], quo_r[TONE_BITS-1]};
  assign ge     = (rem_sh >= {1'b0, div_r});

  assign busy_o     = busy_r;
  assign done_o     = busy_r && (cnt_r == ITER_BITS'(1));
  assign quotient_o = quo_r;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start_i) begin
      busy_nxt = 1'b1;
      cnt_nxt  = ITER_LOAD;
      rem_nxt  = '0;
      quo_nxt  = prod;
    end else if (busy_r) begin
      rem_nxt  = ge ? (rem_sh - {1'b0, div_r}) : rem_sh;
      quo_nxt  = {quo_r[TONE_BITS-2:0], ge};
      cnt_nxt  = cnt_r - ITER_BITS'(1);
      busy_nxt = (cnt_r != ITER_BITS'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start_i) begin
      div_r <= divisor_i;
    end
  end

  `ZCTE_ASSERT(a_no_restart, clk, rst_n, !(start_i && busy_r), "divider restarted while busy")
  `ZCTE_ASSERT(a_done_ends, clk, rst_n, done_o |=> !busy_r, "divider busy after last step")
  `ZCTE_ASSERT(a_busy_cnt, clk, rst_n, busy_r |-> (cnt_r != '0), "divider busy with zero count")

endmodule

// File: hdl/zero_crossing_tone_estimator_core.sv
// Channel  Handshake              Payload
// in       in_valid / in_stall    in_sample[15:0] signed, in_block_end
// out      out_valid / out_stall  out_tone_value[25:0], out_divide_by_zero
// cfg      psel/penable/pwrite    paddr[2:0], pwdata, prdata, pready
//
// An item that closes a block with enough crossings runs the restoring
// divider (one quotient bit per cycle), then the quotient loads the output
// register; a zero interval sum skips the divider. Other items do not raise
// in_stall.
// Reset is synchronous, active low; in_stall is high while a division or a
// pending result is in flight, and a result holds in the output register
// until out_stall drops.
`include "zero_crossing_tone_estimator_core_macros.svh"

module zero_crossing_tone_estimator_core
  import zcte_pkg::*;
#(
  parameter int TIMER_BITS = TIMER_BITS_DEF,
  parameter int SUM_BITS   = SUM_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                     in_block_end,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [TONE_BITS-1:0]     out_tone_value,
  output logic                     out_divide_by_zero,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [CFG_ADDR_BITS-1:0] paddr,
  input  logic [CFG_DATA_BITS-1:0] pwdata,
  output logic [CFG_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  cfg_t                  cfg;
  state_t                state_r, state_nxt;
  logic                  fire, step, emit, sum_zero;
  logic [COUNT_BITS-1:0] count_upd;
  logic [SUM_BITS-1:0]   sum_upd;
  logic                  div_start, div_busy, div_done;
  logic [TONE_BITS-1:0]  quotient;
  logic                  dz_r, dz_nxt;
  logic                  load_out, out_free;
  logic                  out_valid_r;
  logic [TONE_BITS-1:0]  out_tone_value_r;
  logic                  out_divide_by_zero_r;

  zcte_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  zcte_track #(
    .TIMER_BITS (TIMER_BITS),
    .SUM_BITS   (SUM_BITS)
  ) u_track (
    .clk         (clk),
    .rst_n       (rst_n),
    .step_i      (step),
    .clear_i     (emit),
    .sample_i    (in_sample),
    .count_upd_o (count_upd),
    .sum_upd_o   (sum_upd)
  );

  zcte_div #(
    .SUM_BITS (SUM_BITS)
  ) u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (div_start),
    .count_i    (count_upd),
    .divisor_i  (sum_upd),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign fire      = in_valid && !in_stall;
  assign step      = fire && cfg.detect_enable;
  assign emit      = step && in_block_end && (count_upd >= cfg.crossing_target);
  assign sum_zero  = (sum_upd == '0);
  assign div_start = emit && !sum_zero;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    dz_nxt    = dz_r;
    load_out  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (emit) begin
          dz_nxt    = sum_zero;
          state_nxt = sum_zero ? ST_HOLD : ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      dz_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      dz_r    <= dz_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_tone_value_r     <= dz_r ? '0 : quotient;
      out_divide_by_zero_r <= dz_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_tone_value     = out_tone_value_r;
  assign out_divide_by_zero = out_divide_by_zero_r;

  `ZCTE_ASSERT(a_div_state, clk, rst_n, (state_r == ST_DIV) |-> div_busy, "DIV without divider")
  `ZCTE_ASSERT(a_out_src, clk, rst_n, $rose(out_valid_r) |-> $past(state_r == ST_HOLD), "stray item")
  `ZCTE_ASSERT(a_dz_zero, clk, rst_n, (out_valid_r && out_divide_by_zero_r) |-> (out_tone_value_r == '0), "dz item nonzero")
  `ZCTE_ASSERT(a_idle_div, clk, rst_n, (state_r == ST_IDLE) |-> !div_busy, "divider busy in IDLE")

endmodule

// File: tb/tb_zero_crossing_tone_estimator_core.sv
`timescale 1ns / 100ps

module tb_zero_crossing_tone_estimator_core;
  import zcte_pkg::*;

  localparam int TMR_W         = TIMER_BITS_DEF;
  localparam int SUM_W         = SUM_BITS_DEF;
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD     = 400;
  localparam int CYCLE_LIMIT   = 600000;

  typedef struct packed {
    logic [TONE_BITS-1:0] tone;
    logic                 dz;
  } tone_result_t;

  class tone_scoreboard;
    logic                          detect_en;
    logic [COUNT_BITS-1:0]         target;
    logic signed [SAMPLE_BITS-1:0] prev;
    logic [TMR_W-1:0]              timer;
    logic [SUM_W-1:0]              sum;
    logic [COUNT_BITS-1:0]         count;
    tone_result_t                  tone_q[$];
    int                            fails;

    function new();
      detect_en = DETECT_ENABLE_RST;
      target    = CROSSING_TARGET_RST;
      prev      = '0;
      timer     = '0;
      sum       = '0;
      count     = '0;
      fails     = 0;
    endfunction

    function void set_reg(reg_index_t idx, logic [CFG_DATA_BITS-1:0] val);
      if (idx == REG_DETECT_ENABLE) begin
        detect_en = val[0];
      end else begin
        target = val[COUNT_BITS-1:0];
      end
    endfunction

    function void note_sample(logic signed [SAMPLE_BITS-1:0] s, logic be);
      logic [SUM_W:0]  wide_sum;
      tone_result_t    r;
      longint unsigned scaled;
      if (!detect_en) return;
      if ((prev < 0 && s > 0) || (prev > 0 && s < 0)) begin
        wide_sum = {1'b0, sum} + (SUM_W+1)'(timer);
        sum = wide_sum[SUM_W] ? '1 : wide_sum[SUM_W-1:0];
        timer = '0;
        if (count != COUNT_MAX) count++;
      end else if (timer != '1) begin
        timer++;
      end
      prev = s;
      if (be && count >= target) begin
        if (sum == '0) begin
          r.tone = '0;
          r.dz   = 1'b1;
        end else begin
          scaled = (64'(TONE_SCALE) * 64'(count)) / 64'(sum);
          r.tone = scaled[TONE_BITS-1:0];
          r.dz   = 1'b0;
        end
        tone_q.push_back(r);
        count = '0;
        sum   = '0;
      end
    endfunction

    function void check_result(logic [TONE_BITS-1:0] tone, logic dz);
      tone_result_t r;
      if (tone_q.size() == 0) begin
        $display("%0t: unexpected result tone_value %0d divide_by_zero %0b", $time, tone, dz);
        fails++;
        return;
      end
      r = tone_q.pop_front();
      if (tone !== r.tone) begin
        $display("%0t: tone_value expected %0d actual %0d", $time, r.tone, tone);
        fails++;
      end
      if (dz !== r.dz) begin
        $display("%0t: divide_by_zero expected %0b actual %0b", $time, r.dz, dz);
        fails++;
      end
    endfunction

    function int pending();
      return tone_q.size();
    endfunction
  endclass

  logic                          clk          = 1'b0;
  logic                          rst_n        = 1'b0;
  logic                          in_valid     = 1'b0;
  logic                          in_stall;
  logic signed [SAMPLE_BITS-1:0] in_sample    = '0;
  logic                          in_block_end = 1'b0;
  logic                          out_valid;
  logic                          out_stall    = 1'b0;
  logic [TONE_BITS-1:0]          out_tone_value;
  logic                          out_divide_by_zero;
  logic                          psel         = 1'b0;
  logic                          penable      = 1'b0;
  logic                          pwrite       = 1'b0;
  logic [CFG_ADDR_BITS-1:0]      paddr        = '0;
  logic [CFG_DATA_BITS-1:0]      pwdata       = '0;
  logic [CFG_DATA_BITS-1:0]      prdata;
  logic                          pready;

  tone_scoreboard sb = new();
  int             idle_level    = 0;
  bit             long_hold_req = 1'b0;
  int             cycle_cnt     = 0;

  zero_crossing_tone_estimator_core i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sample         (in_sample),
    .in_block_end      (in_block_end),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_tone_value    (out_tone_value),
    .out_divide_by_zero(out_divide_by_zero),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_sample(in_sample, in_block_end);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_tone_value, out_divide_by_zero);
  end

  initial begin : result_stall
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idle_level > 0 && $urandom_range(0, 15) < idle_level) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_item(input logic signed [SAMPLE_BITS-1:0] s, input logic be);
    in_valid     <= 1'b1;
    in_sample    <= s;
    in_block_end <= be;
    do @(posedge clk); while (in_stall);
    if (idle_level > 0 && $urandom_range(0, 15) < idle_level) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input reg_index_t idx, input logic [CFG_DATA_BITS-1:0] val);
    logic [CFG_DATA_BITS-1:0] mask;
    mask = (idx == REG_DETECT_ENABLE) ? 32'h1 : 32'h3F;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_BITS'(4 * int'(idx));
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_reg(idx, val);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if ((prdata & mask) !== (val & mask)) begin
      $display("%0t: register %0d readback expected %0h actual %0h", $time, int'(idx),
               val & mask, prdata & mask);
      sb.fails++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic gen_tone(input int n, input int max_h, input int min_len, input int max_len);
    bit                            pos;
    int                            half;
    int                            run;
    int                            blk_len;
    int                            blk_pos;
    logic signed [SAMPLE_BITS-1:0] s;
    logic                          be;
    pos     = 1'($urandom_range(0, 1));
    half    = $urandom_range(1, max_h);
    run     = 0;
    blk_len = $urandom_range(min_len, max_len);
    blk_pos = 0;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 15) == 0) begin
        s = SAMPLE_BITS'($urandom);
      end else if ($urandom_range(0, 31) == 0) begin
        s = '0;
      end else begin
        s = SAMPLE_BITS'($urandom_range(1, 32767));
        if (!pos) s = -s;
      end
      run++;
      if (run >= half) begin
        run = 0;
        pos = !pos;
        if ($urandom_range(0, 3) == 0) half = $urandom_range(1, max_h);
      end
      blk_pos++;
      be = (blk_pos >= blk_len) || ($urandom_range(0, 63) == 0);
      if (be) begin
        blk_pos = 0;
        blk_len = $urandom_range(min_len, max_len);
      end
      send_item(s, be);
    end
  endtask

  task automatic run_segment(input logic en, input int tgt, input int n, input int max_h,
                             input int min_len, input int max_len);
    settle();
    cfg_write(REG_DETECT_ENABLE, 32'(en));
    cfg_write(REG_CROSSING_TARGET, 32'(tgt));
    gen_tone(n, max_h, min_len, max_len);
  endtask

  initial begin : main_seq
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    idle_level = 4;

    send_item(16'sh7FFF, 1'b0);
    send_item(-16'sh8000, 1'b0);
    send_item(16'sh0000, 1'b0);
    send_item(-16'sh0001, 1'b0);
    send_item(16'sh0001, 1'b0);
    send_item(16'sh7FFF, 1'b1);

    settle();
    cfg_write(REG_CROSSING_TARGET, 32'd1);
    send_item(-16'sh8000, 1'b1);
    send_item(16'sh0001, 1'b1);
    send_item(16'sh0000, 1'b1);

    settle();
    cfg_write(REG_CROSSING_TARGET, 32'd0);
    send_item(16'sh0000, 1'b1);
    send_item(16'sh0064, 1'b1);

    settle();
    cfg_write(REG_DETECT_ENABLE, 32'd0);
    send_item(-16'sh0064, 1'b1);
    send_item(16'sh0064, 1'b1);

    settle();
    cfg_write(REG_DETECT_ENABLE, 32'd1);
    cfg_write(REG_CROSSING_TARGET, 32'd63);
    for (int i = 0; i < 8; i++) send_item(i[0] ? 16'sh5555 : -16'sh5556, i == 7);

    idle_level = 3;
    run_segment(1'b1, 30, 200, 6, 40, 120);
    settle();
    cfg_write(REG_DETECT_ENABLE, 32'd1);
    cfg_write(REG_CROSSING_TARGET, 32'd1);
    long_hold_req = 1'b1;
    gen_tone(80, 3, 1, 4);
    idle_level = 6;
    run_segment(1'b1, 63, 150, 3, 80, 200);
    run_segment(1'b1, 0, 50, 4, 1, 10);
    run_segment(1'b0, 1, 40, 3, 1, 5);
    idle_level = 2;
    run_segment(1'b1, $urandom_range(1, 20), 120, 5, 5, 40);
    run_segment(1'b1, $urandom_range(0, 63), 120, 4, 10, 150);
    idle_level = 0;
    run_segment(1'b1, $urandom_range(1, 10), 180, 4, 3, 30);

    settle();
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hdl
hdl/zcte_pkg.sv
hdl/zcte_regs.sv
hdl/zcte_track.sv
hdl/zcte_div.sv
hdl/zero_crossing_tone_estimator_core.sv
tb/tb_zero_crossing_tone_estimator_core.sv
